// File: rtl/osptt_pkg.sv
// ----------------------------------------------------------------------------
// osptt_pkg: shared types and constants of the millisecond timer table
// Request and result beat layouts, table entry layout, opcodes and result kinds.
// ----------------------------------------------------------------------------
package osptt_pkg;

  localparam int TIME_W     = 48;
  localparam int ID_W       = 32;
  localparam int DLY_W      = 31;
  localparam int RESULT_CAP = 16;

  localparam logic [1:0] OP_SCHEDULE  = 2'd0;
  localparam logic [1:0] OP_CLEAR     = 2'd1;
  localparam logic [1:0] OP_TICK      = 2'd2;
  localparam logic [1:0] OP_CLEAR_ALL = 2'd3;

  localparam logic [1:0] KIND_ASSIGNED = 2'd0;
  localparam logic [1:0] KIND_FIRED    = 2'd1;
  localparam logic [1:0] KIND_FULL     = 2'd2;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  typedef struct packed {
    logic [1:0]        opcode;
    logic signed [31:0] delay_ms;
    logic              periodic;
    logic [ID_W-1:0]   target_id;
    logic [TIME_W-1:0] tick_time_ms;
  } in_t;

  typedef struct packed {
    logic [1:0]      result_kind;
    logic [ID_W-1:0] timer_id;
    logic            last;
  } out_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [DLY_W-1:0]  delay;
    logic [TIME_W-1:0] due;
    logic              repeats;
  } ent_t;

endpackage

// File: rtl/one_shot_periodic_timer_table.sv
// ----------------------------------------------------------------------------
// one_shot_periodic_timer_table: table of one-shot and periodic ms timers
// Schedules, clears and fires timers with one shared comparator and adder.
// ----------------------------------------------------------------------------
// Busy per beat: schedule scans for a free slot, clear scans for the id, clear all
// stays idle; a tick scans to mark due entries, then fires at most 16 timers, lowest
// id first, by select scans until one finds none or the 16th has fired.
// Each result strobes the cycle after the one that decides it; a new beat is taken
// as soon as busy is low, and the receiver cannot stall results.
// Reset (synchronous, rst_n low) frees all entries, next id 1, last tick time 0.
// ----------------------------------------------------------------------------
module one_shot_periodic_timer_table #(
  parameter int MAX_TIMERS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  osptt_pkg::in_t    in_item,
  output logic              out_valid,
  output osptt_pkg::out_t   out_item
);

  localparam int IW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
  localparam int CW = $clog2(osptt_pkg::RESULT_CAP + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(MAX_TIMERS - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCHED,
    ST_CLEAR,
    ST_MARK,
    ST_SELECT,
    ST_UPDATE,
    ST_FINAL
  } state_t;

  // Control state.
  state_t                       state_r, state_nxt;
  logic [MAX_TIMERS-1:0]        active_r, active_nxt;
  logic [osptt_pkg::ID_W-1:0]   next_id_r, next_id_nxt;
  logic [osptt_pkg::TIME_W-1:0] last_tick_r, last_tick_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [IW-1:0]                rd_idx_r, rd_idx_nxt;
  logic                         issue_r, issue_nxt;
  logic                         pv_r, pv_nxt;
  logic                         best_vld_r, best_vld_nxt;
  logic                         pend_vld_r, pend_vld_nxt;
  logic [CW-1:0]                count_r, count_nxt;

  // Datapath registers.
  osptt_pkg::in_t               req_r, req_nxt;
  logic [IW-1:0]                pidx_r, pidx_nxt;
  logic [MAX_TIMERS-1:0]        cand_r, cand_nxt;
  logic [IW-1:0]                best_idx_r, best_idx_nxt;
  osptt_pkg::ent_t              best_r, best_nxt;
  logic [osptt_pkg::ID_W-1:0]   pend_id_r, pend_id_nxt;
  osptt_pkg::out_t              out_r, out_nxt;

  // Timer table: one write port, one registered read port.
  osptt_pkg::ent_t              mem [MAX_TIMERS];
  osptt_pkg::ent_t              rdata_r;
  logic                         we_c;
  logic [IW-1:0]                wa_c;
  osptt_pkg::ent_t              wd_c;

  // Shared comparator and saturating adder.
  logic [osptt_pkg::TIME_W-1:0] cmp_a, cmp_b;
  logic                         cmp_lt, cmp_eq;
  logic [osptt_pkg::DLY_W-1:0]  add_b;
  logic [osptt_pkg::TIME_W:0]   add_sum;
  logic [osptt_pkg::TIME_W-1:0] sat_sum;

  // Helper values.
  logic [osptt_pkg::DLY_W-1:0]  sched_d;
  logic [osptt_pkg::ID_W-1:0]   id_inc;
  logic                         scan_last;
  logic                         take;
  logic                         best_vld_new;

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // A negative delay counts as zero.
  assign sched_d = req_r.delay_ms[31] ? '0 : req_r.delay_ms[30:0];
  assign id_inc  = next_id_r + 1'b1;

  // The single comparator serves the due check while marking, the id
  // ordering while selecting and the id match while clearing.
  always_comb begin
    case (state_r)
      ST_MARK: begin
        cmp_a = rdata_r.due;
        cmp_b = last_tick_r;
      end
      ST_SELECT: begin
        cmp_a = osptt_pkg::TIME_W'(rdata_r.id);
        cmp_b = osptt_pkg::TIME_W'(best_r.id);
      end
      default: begin
        cmp_a = osptt_pkg::TIME_W'(rdata_r.id);
        cmp_b = osptt_pkg::TIME_W'(req_r.target_id);
      end
    endcase
  end
  assign cmp_lt = (cmp_a < cmp_b);
  assign cmp_eq = (cmp_a == cmp_b);

  // The single adder forms the first due time on schedule and the re-arm
  // time on a tick; last_tick_r already holds the tick timestamp then.
  always_comb begin
    if (state_r == ST_UPDATE) begin
      add_b = (best_r.delay == '0) ? osptt_pkg::DLY_W'(1) : best_r.delay;
    end else begin
      add_b = sched_d;
    end
  end
  assign add_sum = {1'b0, last_tick_r} + (osptt_pkg::TIME_W + 1)'(add_b);
  assign sat_sum = add_sum[osptt_pkg::TIME_W] ? osptt_pkg::TIME_MAX
                                              : add_sum[osptt_pkg::TIME_W-1:0];

  // The read pipeline delivers the entry at pidx_r while pv_r is set.
  assign scan_last    = pv_r && (pidx_r == LAST_IDX);
  assign take         = pv_r && cand_r[pidx_r] && (!best_vld_r || cmp_lt);
  assign best_vld_new = best_vld_r || take;

  always_comb begin
    state_nxt     = state_r;
    active_nxt    = active_r;
    next_id_nxt   = next_id_r;
    last_tick_nxt = last_tick_r;
    out_valid_nxt = 1'b0;
    rd_idx_nxt    = rd_idx_r;
    issue_nxt     = issue_r;
    pv_nxt        = 1'b0;
    best_vld_nxt  = best_vld_r;
    pend_vld_nxt  = pend_vld_r;
    count_nxt     = count_r;
    req_nxt       = req_r;
    pidx_nxt      = pidx_r;
    cand_nxt      = cand_r;
    best_idx_nxt  = best_idx_r;
    best_nxt      = best_r;
    pend_id_nxt   = pend_id_r;
    out_nxt       = out_r;
    we_c          = 1'b0;
    wa_c          = rd_idx_r;
    wd_c          = best_r;

    // Sequential read of the table, one address a cycle.
    if (state_r == ST_CLEAR || state_r == ST_MARK || state_r == ST_SELECT) begin
      if (issue_r) begin
        pv_nxt   = 1'b1;
        pidx_nxt = rd_idx_r;
        if (rd_idx_r == LAST_IDX) begin
          issue_nxt = 1'b0;
        end else begin
          rd_idx_nxt = rd_idx_r + 1'b1;
        end
      end
    end

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          req_nxt    = in_item;
          rd_idx_nxt = '0;
          issue_nxt  = 1'b1;
          case (in_item.opcode)
            osptt_pkg::OP_SCHEDULE: state_nxt = ST_SCHED;
            osptt_pkg::OP_CLEAR:    state_nxt = ST_CLEAR;
            osptt_pkg::OP_TICK: begin
              state_nxt     = ST_MARK;
              last_tick_nxt = in_item.tick_time_ms;
              count_nxt     = '0;
              pend_vld_nxt  = 1'b0;
            end
            osptt_pkg::OP_CLEAR_ALL: active_nxt = '0;
            default: state_nxt = ST_IDLE;
          endcase
        end
      end

      ST_SCHED: begin
        if (!active_r[rd_idx_r]) begin
          we_c                  = 1'b1;
          wd_c.id               = next_id_r;
          wd_c.delay            = (req_r.periodic && sched_d == '0)
                                  ? osptt_pkg::DLY_W'(1) : sched_d;
          wd_c.due              = sat_sum;
          wd_c.repeats          = req_r.periodic;
          active_nxt[rd_idx_r]  = 1'b1;
          out_valid_nxt         = 1'b1;
          out_nxt.result_kind   = osptt_pkg::KIND_ASSIGNED;
          out_nxt.timer_id      = next_id_r;
          out_nxt.last          = 1'b1;
          next_id_nxt           = (id_inc == '0) ? osptt_pkg::ID_W'(1) : id_inc;
          state_nxt             = ST_IDLE;
        end else if (rd_idx_r == LAST_IDX) begin
          out_valid_nxt         = 1'b1;
          out_nxt.result_kind   = osptt_pkg::KIND_FULL;
          out_nxt.timer_id      = '0;
          out_nxt.last          = 1'b1;
          state_nxt             = ST_IDLE;
        end else begin
          rd_idx_nxt = rd_idx_r + 1'b1;
        end
      end

      ST_CLEAR: begin
        if (pv_r && active_r[pidx_r] && cmp_eq) begin
          active_nxt[pidx_r] = 1'b0;
          state_nxt          = ST_IDLE;
        end else if (scan_last) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_MARK: begin
        if (pv_r) begin
          cand_nxt[pidx_r] = active_r[pidx_r] && (cmp_lt || cmp_eq);
        end
        if (scan_last) begin
          state_nxt    = ST_SELECT;
          rd_idx_nxt   = '0;
          issue_nxt    = 1'b1;
          pv_nxt       = 1'b0;
          best_vld_nxt = 1'b0;
        end
      end

      ST_SELECT: begin
        // Strict less-than keeps the lower slot on equal ids.
        if (take) begin
          best_vld_nxt = 1'b1;
          best_idx_nxt = pidx_r;
          best_nxt     = rdata_r;
        end
        if (scan_last) begin
          if (best_vld_new) begin
            state_nxt = ST_UPDATE;
          end else begin
            if (pend_vld_r) begin
              out_valid_nxt       = 1'b1;
              out_nxt.result_kind = osptt_pkg::KIND_FIRED;
              out_nxt.timer_id    = pend_id_r;
              out_nxt.last        = 1'b1;
            end
            state_nxt = ST_IDLE;
          end
        end
      end

      ST_UPDATE: begin
        cand_nxt[best_idx_r] = 1'b0;
        if (best_r.repeats) begin
          we_c     = 1'b1;
          wa_c     = best_idx_r;
          wd_c.due = sat_sum;
        end else begin
          active_nxt[best_idx_r] = 1'b0;
        end
        // The previous fired id goes out now; the newest one is held back
        // until it is known whether it is the final beat.
        if (pend_vld_r) begin
          out_valid_nxt       = 1'b1;
          out_nxt.result_kind = osptt_pkg::KIND_FIRED;
          out_nxt.timer_id    = pend_id_r;
          out_nxt.last        = 1'b0;
        end
        pend_vld_nxt = 1'b1;
        pend_id_nxt  = best_r.id;
        count_nxt    = count_r + 1'b1;
        if (count_r == CW'(osptt_pkg::RESULT_CAP - 1)) begin
          state_nxt = ST_FINAL;
        end else begin
          state_nxt    = ST_SELECT;
          rd_idx_nxt   = '0;
          issue_nxt    = 1'b1;
          best_vld_nxt = 1'b0;
        end
      end

      ST_FINAL: begin
        out_valid_nxt       = 1'b1;
        out_nxt.result_kind = osptt_pkg::KIND_FIRED;
        out_nxt.timer_id    = pend_id_r;
        out_nxt.last        = 1'b1;
        state_nxt           = ST_IDLE;
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      active_r    <= '0;
      next_id_r   <= osptt_pkg::ID_W'(1);
      last_tick_r <= '0;
      out_valid_r <= 1'b0;
      rd_idx_r    <= '0;
      issue_r     <= 1'b0;
      pv_r        <= 1'b0;
      best_vld_r  <= 1'b0;
      pend_vld_r  <= 1'b0;
      count_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      next_id_r   <= next_id_nxt;
      last_tick_r <= last_tick_nxt;
      out_valid_r <= out_valid_nxt;
      rd_idx_r    <= rd_idx_nxt;
      issue_r     <= issue_nxt;
      pv_r        <= pv_nxt;
      best_vld_r  <= best_vld_nxt;
      pend_vld_r  <= pend_vld_nxt;
      count_r     <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    pidx_r     <= pidx_nxt;
    cand_r     <= cand_nxt;
    best_idx_r <= best_idx_nxt;
    best_r     <= best_nxt;
    pend_id_r  <= pend_id_nxt;
    out_r      <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (we_c) begin
      mem[wa_c] <= wd_c;
    end
    rdata_r <= mem[rd_idx_r];
  end

endmodule

// File: dv/osptt_check_pkg.sv
// ----------------------------------------------------------------------------
// osptt_check_pkg: result tracking for the timer table testbench
// Keeps a shadow copy of the timer table, works out the result beats that
// each accepted request beat causes, and matches them against the block.
// ----------------------------------------------------------------------------
package osptt_check_pkg;

  import osptt_pkg::*;

  localparam int TABLE_SLOTS = 16;

  class timer_table_tracker;

    bit              slot_active [TABLE_SLOTS];
    bit [ID_W-1:0]   slot_id     [TABLE_SLOTS];
    bit [DLY_W-1:0]  slot_delay  [TABLE_SLOTS];
    bit [TIME_W-1:0] slot_due    [TABLE_SLOTS];
    bit              slot_repeats[TABLE_SLOTS];
    bit [ID_W-1:0]   id_counter;
    bit [TIME_W-1:0] last_tick_ms;
    out_t            awaited_events[$];
    int              mismatches;

    function new();
      id_counter   = 1;
      last_tick_ms = '0;
      mismatches   = 0;
    endfunction

    function bit [TIME_W-1:0] capped_sum(bit [TIME_W-1:0] base, bit [DLY_W-1:0] wait_ms);
      bit [TIME_W:0] total;
      total = {1'b0, base} + (TIME_W + 1)'(wait_ms);
      return total[TIME_W] ? TIME_MAX : total[TIME_W-1:0];
    endfunction

    function void push_event(logic [1:0] kind, logic [ID_W-1:0] id, logic last);
      out_t ev;
      ev.result_kind = kind;
      ev.timer_id    = id;
      ev.last        = last;
      awaited_events = {awaited_events, ev};
    endfunction

    // Updates the shadow table for one accepted request beat and queues the
    // result beats it should produce.
    function void record_request(in_t req);
      bit [DLY_W-1:0] wait_ms;
      bit             due_now[TABLE_SLOTS];
      bit             hit;
      int             free_slot;
      int             fired;
      int             pick;
      out_t           tail;
      case (req.opcode)
        OP_SCHEDULE: begin
          wait_ms   = req.delay_ms[31] ? '0 : req.delay_ms[DLY_W-1:0];
          free_slot = -1;
          for (int i = TABLE_SLOTS - 1; i >= 0; i--)
            if (!slot_active[i]) free_slot = i;
          if (free_slot < 0) begin
            push_event(KIND_FULL, '0, 1'b1);
          end else begin
            slot_active[free_slot]  = 1'b1;
            slot_id[free_slot]      = id_counter;
            slot_due[free_slot]     = capped_sum(last_tick_ms, wait_ms);
            slot_repeats[free_slot] = req.periodic;
            // A periodic timer never re-arms with a zero period.
            slot_delay[free_slot]   = (req.periodic && wait_ms == 0) ? DLY_W'(1) : wait_ms;
            push_event(KIND_ASSIGNED, id_counter, 1'b1);
            id_counter = id_counter + 1;
            if (id_counter == 0) id_counter = 1;
          end
        end
        OP_CLEAR: begin
          hit = 1'b0;
          for (int i = 0; i < TABLE_SLOTS; i++) begin
            if (!hit && slot_active[i] && slot_id[i] == req.target_id) begin
              slot_active[i] = 1'b0;
              hit = 1'b1;
            end
          end
        end
        OP_CLEAR_ALL: begin
          foreach (slot_active[i]) slot_active[i] = 1'b0;
        end
        OP_TICK: begin
          last_tick_ms = req.tick_time_ms;
          foreach (due_now[i])
            due_now[i] = slot_active[i] && slot_due[i] <= req.tick_time_ms;
          fired = 0;
          pick  = 0;
          while (fired < RESULT_CAP && pick >= 0) begin
            pick = -1;
            for (int i = 0; i < TABLE_SLOTS; i++)
              if (due_now[i] && (pick < 0 || slot_id[i] < slot_id[pick])) pick = i;
            if (pick >= 0) begin
              due_now[pick] = 1'b0;
              push_event(KIND_FIRED, slot_id[pick], 1'b0);
              fired++;
              if (slot_repeats[pick])
                slot_due[pick] = capped_sum(req.tick_time_ms,
                                            (slot_delay[pick] == 0) ? DLY_W'(1)
                                                                    : slot_delay[pick]);
              else
                slot_active[pick] = 1'b0;
            end
          end
          if (fired > 0) begin
            tail = awaited_events[awaited_events.size() - 1];
            tail.last = 1'b1;
            awaited_events[awaited_events.size() - 1] = tail;
          end
        end
        default: begin
        end
      endcase
    endfunction

    function void check_event(out_t got);
      out_t want;
      if (awaited_events.size() == 0) begin
        $error("result beat with nothing awaited: result_kind %0d timer_id %0d last %0d",
               got.result_kind, got.timer_id, got.last);
        mismatches++;
        return;
      end
      want = awaited_events.pop_front();
      if (got.result_kind !== want.result_kind) begin
        $error("result_kind mismatch: expected %0d, actual %0d",
               want.result_kind, got.result_kind);
        mismatches++;
      end
      if (got.timer_id !== want.timer_id) begin
        $error("timer_id mismatch: expected %0d, actual %0d", want.timer_id, got.timer_id);
        mismatches++;
      end
      if (got.last !== want.last) begin
        $error("last mismatch: expected %0d, actual %0d", want.last, got.last);
        mismatches++;
      end
    endfunction

    function int outstanding();
      return awaited_events.size();
    endfunction

  endclass

endpackage

// File: dv/one_shot_periodic_timer_table_test.sv
// ----------------------------------------------------------------------------
// one_shot_periodic_timer_table_test: self-checking test of the timer table
// Drives schedule, clear, tick and clear-all beats into the block, first a
// directed set of corner cases and then a long random run, and checks every
// result beat against a shadow table kept by the tracker class.
// ----------------------------------------------------------------------------
module one_shot_periodic_timer_table_test;

  import osptt_pkg::*;
  import osptt_check_pkg::*;

  localparam int RANDOM_BEATS = 430;
  // The last stretch of the random run is sent back to back.
  localparam int CALM_TAIL    = 60;
  // Worst-case tick: one marking pass plus sixteen fired timers, with margin.
  localparam int DRAIN_CYCLES = (TABLE_SLOTS + 1) + RESULT_CAP * (TABLE_SLOTS + 2) + 16;
  // Cycles without any accepted beat before the run is declared hung.
  localparam int STALL_LIMIT  = 4000;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              start     = 1'b0;
  in_t               in_item   = '0;
  logic              busy;
  logic              out_valid;
  out_t              out_item;

  timer_table_tracker board;
  // Stimulus view of "now"; every random tick uses it as its timestamp.
  logic [TIME_W-1:0] clock_ms  = '0;
  bit                idle_mode = 1'b0;
  int                quiet_cycles = 0;

  one_shot_periodic_timer_table #(
    .MAX_TIMERS(TABLE_SLOTS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // All sampling happens at the rising edge, before the block's own updates
  // land, so results are checked first and then the newly accepted request
  // beat is folded into the shadow table. A request's results can never
  // appear at the edge that accepts it, so this order is safe.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) board.check_event(out_item);
      if (start && !busy) board.record_request(in_item);
    end
  end

  // Hang detector: any accepted beat in either direction restarts the count.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $error("no beat accepted for %0d cycles", quiet_cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic in_t make_beat(logic [1:0] op, logic signed [31:0] dly, logic rep,
                                    logic [ID_W-1:0] target, logic [TIME_W-1:0] stamp);
    in_t req;
    req.opcode       = op;
    req.delay_ms     = dly;
    req.periodic     = rep;
    req.target_id    = target;
    req.tick_time_ms = stamp;
    return req;
  endfunction

  // Presents one request beat and returns at the edge that accepts it. The
  // caller decides whether start drops afterwards, so start is never lowered
  // and raised again within one time step.
  task automatic send_beat(input in_t req);
    start   <= 1'b1;
    in_item <= req;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // Holds the sender off until every awaited result beat has come back. The
  // first edge lets the monitor record the beat accepted just before.
  task automatic hold_until_quiet();
    start <= 1'b0;
    do @(posedge clk); while (board.outstanding() != 0);
  endtask

  initial begin
    in_t               req;
    int unsigned       roll;
    int unsigned       sub;
    int unsigned       pick;
    logic [TIME_W-1:0] advance;
    int                idx;

    board = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // ---- Directed corner cases ----
    // Ids 1 to 4: zero one-shot, zero periodic (stored period becomes one),
    // the most negative delay (clamped to zero) and the largest delay.
    send_beat(make_beat(OP_SCHEDULE, 32'sd0, 1'b0, '0, '0));
    send_beat(make_beat(OP_SCHEDULE, 32'sd0, 1'b1, '0, '0));
    send_beat(make_beat(OP_SCHEDULE, 32'sh8000_0000, 1'b0, '0, '0));
    send_beat(make_beat(OP_SCHEDULE, 32'sh7FFF_FFFF, 1'b1, '0, '0));
    // Clearing id zero must do nothing; clearing id 3 frees its slot.
    send_beat(make_beat(OP_CLEAR, '0, 1'b0, '0, '0));
    send_beat(make_beat(OP_CLEAR, '0, 1'b0, 32'd3, '0));
    // Ids 1 and 2 fire at time zero; the periodic one re-arms one ms later.
    send_beat(make_beat(OP_TICK, '0, 1'b0, '0, '0));
    // At the largest timestamp both periodic timers fire and re-arm saturated.
    send_beat(make_beat(OP_TICK, '0, 1'b0, '0, TIME_MAX));
    // Due time of id 5 saturates, then time runs backward with nothing due.
    send_beat(make_beat(OP_SCHEDULE, 32'sd5, 1'b0, '0, '0));
    send_beat(make_beat(OP_TICK, '0, 1'b0, '0, 48'd3));
    // Fill the remaining thirteen slots, the last one with a delay of minus one.
    for (int k = 0; k < 13; k++)
      send_beat(make_beat(OP_SCHEDULE, (k == 12) ? -32'sd1 : 32'(k * 3), k[0], '0, '0));
    // The table is full now, and then every entry fires in one tick.
    send_beat(make_beat(OP_SCHEDULE, 32'sd1, 1'b0, '0, '0));
    send_beat(make_beat(OP_TICK, '0, 1'b0, '0, TIME_MAX));
    send_beat(make_beat(OP_CLEAR_ALL, '0, 1'b0, '0, '0));
    hold_until_quiet();
    clock_ms = '0;

    // ---- Random run ----
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      // Fields that the opcode ignores still carry random noise.
      req.opcode       = OP_SCHEDULE;
      req.delay_ms     = $urandom;
      req.periodic     = 1'($urandom_range(0, 1));
      req.target_id    = $urandom;
      req.tick_time_ms = {16'($urandom), $urandom};
      roll = $urandom_range(0, 99);
      sub  = $urandom_range(0, 9);

      if (roll < 42) begin
        // Mostly short delays so that timers actually come due.
        if (sub < 6) req.delay_ms = $urandom_range(0, 40);
        else if (sub == 6) req.delay_ms = $urandom | 32'h8000_0000;
        else if (sub == 7) req.delay_ms = $urandom_range(0, 2000);
        else if (sub == 8) req.delay_ms = $urandom & 32'h7FFF_FFFF;
      end else if (roll < 77) begin
        req.opcode = OP_TICK;
        if (sub == 7) begin
          clock_ms = (clock_ms > 48'd50) ? clock_ms - TIME_W'($urandom_range(0, 50)) : '0;
        end else if (sub == 8) begin
          clock_ms = {16'($urandom), $urandom};
        end else if (sub == 9) begin
          clock_ms = $urandom_range(0, 1) ? TIME_MAX : 48'($urandom_range(0, 100));
        end else begin
          advance  = TIME_W'($urandom_range(0, 30));
          clock_ms = (TIME_MAX - clock_ms < advance) ? TIME_MAX : clock_ms + advance;
        end
        req.tick_time_ms = clock_ms;
      end else if (roll < 95) begin
        req.opcode = OP_CLEAR;
        if (sub < 7) begin
          // Aim at a live timer where there is one, else at an id not yet issued.
          req.target_id = board.id_counter;
          pick = $urandom_range(0, TABLE_SLOTS - 1);
          for (int k = 0; k < TABLE_SLOTS; k++) begin
            idx = (pick + k) % TABLE_SLOTS;
            if (board.slot_active[idx]) req.target_id = board.slot_id[idx];
          end
        end else if (sub == 7) begin
          req.target_id = '0;
        end else if (sub == 8) begin
          req.target_id = board.id_counter;
        end
      end else begin
        req.opcode = OP_CLEAR_ALL;
      end

      send_beat(req);

      // Sender idling comes in bursts, switched on and off in stretches.
      if (n % 40 == 0) idle_mode = ($urandom_range(0, 3) != 0);
      if (n % 100 == 99 && n < RANDOM_BEATS - CALM_TAIL) begin
        hold_until_quiet();
      end else if (idle_mode && n < RANDOM_BEATS - CALM_TAIL && $urandom_range(0, 2) == 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
    end

    // Let the last beats finish, including ones that produce no result.
    hold_until_quiet();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
